// ===== design/psh_pkg.sv =====
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants for the pixel swap HSV error block
// Holds the beat payload structs, opcodes, sequencer states and HSV constants.
// ----------------------------------------------------------------------------
package psh_pkg;

  // Image side in pixels; coordinates are 8 bits, so one byte covers a side
  localparam int IMAGE_SIDE = 256;

  typedef enum logic [1:0] {
    OP_WRITE_SRC = 2'd0,
    OP_WRITE_TGT = 2'd1,
    OP_TRIAL     = 2'd2,
    OP_READ_SRC  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  x_first;
    logic [7:0]  y_first;
    logic [7:0]  x_second;
    logic [7:0]  y_second;
    logic [23:0] pixel_value;
  } in_beat_t;

  typedef struct packed {
    logic        swapped;
    logic [23:0] read_pixel;
    logic [31:0] improvement_count;
    logic [31:0] trial_count;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_CV_SA,
    ST_CV_SB,
    ST_CV_TA,
    ST_CV_TB,
    ST_SUM,
    ST_ERR,
    ST_WB_A,
    ST_WB_B,
    ST_DONE
  } state_t;

  // Converter handshake, one HSV conversion per request
  typedef struct packed {
    logic        start;
    logic [23:0] rgb;
  } cvt_req_t;

  typedef struct packed {
    logic               done;
    logic signed [13:0] h;
    logic [11:0]        s;
    logic [11:0]        v;
  } cvt_rsp_t;

  localparam logic signed [13:0] GRAY_HUE = -14'sd4096;
  localparam logic [8:0] W_HUE = 9'd230;
  localparam logic [8:0] W_SAT = 9'd256;
  localparam logic [8:0] W_VAL = 9'd282;

endpackage

// ===== design/psh_div.sv =====
// ----------------------------------------------------------------------------
// psh_div: restoring divider, one quotient bit per cycle
// Divides a 24-bit numerator by a 12-bit denominator.
// ----------------------------------------------------------------------------
module psh_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [11:0] den,
  output logic        done,
  output logic [23:0] quot
);

  logic [4:0]  count;
  logic        running;
  logic [12:0] rem;
  logic [23:0] q;
  logic [12:0] trial;
  logic [12:0] shifted;

  assign shifted = {rem[11:0], q[23]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= 5'd0;
        rem     <= '0;
        q       <= num;
      end else if (running) begin
        // shift in one numerator bit, subtract when it fits
        if (!trial[12]) begin
          rem <= trial;
          q   <= {q[22:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[22:0], 1'b0};
        end
        count <= count + 5'd1;
        if (count == 5'd23) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

// ===== design/psh_hsv.sv =====
// ----------------------------------------------------------------------------
// psh_hsv: RGB to fixed-point HSV converter
// Derives V by reciprocal multiply, then, unless the pixel is gray, runs the S and H
// divisions in turn through one shared divider.
// ----------------------------------------------------------------------------
module psh_hsv (
  input  logic                clk,
  input  logic                rst,
  input  psh_pkg::cvt_req_t   req,
  output psh_pkg::cvt_rsp_t   rsp
);

  logic [7:0]  mx, mn, d, r, g, b;
  logic [1:0]  phase;
  logic        active;
  logic        div_start;
  logic [23:0] div_num;
  logic [11:0] div_den;
  logic        div_done;
  logic [23:0] div_quot;
  logic [11:0] v_reg, s_reg;
  logic [12:0] hnum;
  logic [23:0] hq;
  logic [15:0] v_prod;
  logic [11:0] v_calc;

  always_comb begin
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    // V = 16*mx + floor((mx + 8) / 17), the divide by 17 as a multiply by 241
    v_prod = 16'({1'b0, mx} + 9'd8) * 16'd241;
    v_calc = {mx, 4'b0000} + 12'(v_prod[15:12]);
    // hue numerator in 0..6d, already wrapped positive
    if (r == mx) begin
      hnum = (g >= b) ? {5'd0, g - b} : 13'({d, 1'b0} * 3) - 13'(b - g);
    end else if (g == mx) begin
      hnum = 13'({d, 1'b0}) + 13'(b) - 13'(r);
    end else begin
      hnum = 13'({d, 2'b0}) + 13'(r) - 13'(g);
    end
  end

  always_comb begin
    div_num = '0;
    div_den = 12'd1;
    unique case (phase)
      2'd1: begin
        div_num = 24'(d) * 24'd4095 + 24'(mx >> 1);
        div_den = 12'(mx);
      end
      default: begin
        div_num = 24'(hnum) * 24'd4096 + 24'(d) * 24'd3;
        div_den = 12'(d) * 12'd6;
      end
    endcase
  end

  psh_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign hq = (div_quot >= 24'd4096) ? div_quot - 24'd4096 : div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      div_start <= 1'b0;
      phase     <= 2'd0;
      rsp.done  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rsp.done  <= 1'b0;
      if (req.start) begin
        r         <= req.rgb[23:16];
        g         <= req.rgb[15:8];
        b         <= req.rgb[7:0];
        phase     <= 2'd0;
        active    <= 1'b1;
      end else if (active && (phase == 2'd0 || div_done)) begin
        unique case (phase)
          2'd0: begin
            v_reg <= v_calc;
            if (d == 8'd0) begin
              rsp.v    <= v_calc;
              rsp.s    <= '0;
              rsp.h    <= psh_pkg::GRAY_HUE;
              rsp.done <= 1'b1;
              active   <= 1'b0;
            end else begin
              phase     <= 2'd1;
              div_start <= 1'b1;
            end
          end
          2'd1: begin
            s_reg     <= div_quot[11:0];
            phase     <= 2'd2;
            div_start <= 1'b1;
          end
          default: begin
            rsp.v    <= v_reg;
            rsp.s    <= s_reg;
            rsp.h    <= $signed({2'b00, hq[11:0]});
            rsp.done <= 1'b1;
            active   <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/pixel_swap_hsv_error.sv =====
// ----------------------------------------------------------------------------
// pixel_swap_hsv_error: swap trial of two source pixels by weighted HSV error
// Source and target images in block memories, one shared HSV converter.
// ----------------------------------------------------------------------------
// Writes and reads raise the result strobe after the RD_A and DONE states. A swap trial
// raises it after RD_A, RD_B, four conversions (gray pixels skip the two divider runs
// for S and H), SUM, ERR, then WB_A and WB_B when it swaps, and DONE.
// busy drops in the strobe cycle; a new beat is taken only once the last one is through.
// The receiver cannot stall: out_valid marks one cycle.
// Reset clears the counters and sequencer; image contents stay undefined.
module pixel_swap_hsv_error (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  psh_pkg::in_beat_t   in_beat,
  output logic                busy,
  output logic                out_valid,
  output psh_pkg::out_beat_t  out_beat
);

  localparam int AW = $clog2(psh_pkg::IMAGE_SIDE);
  localparam int DEPTH = psh_pkg::IMAGE_SIDE * psh_pkg::IMAGE_SIDE;

  psh_pkg::state_t state, state_next;
  psh_pkg::in_beat_t cmd;

  logic [23:0] src_mem [DEPTH];
  logic [23:0] tgt_mem [DEPTH];

  logic [2*AW-1:0] addr_a, addr_b, rd_addr;
  logic [23:0] src_q, tgt_q;
  logic [23:0] sa, sb, ta, tb;
  logic signed [13:0] h [4];
  logic [11:0] s [4], v [4];
  logic [33:0] cur_err, alt_err;
  logic [31:0] improvements, trials;
  logic        do_swap;
  logic        src_we;
  logic [2*AW-1:0] src_waddr;
  logic [23:0] src_wdata;

  psh_pkg::cvt_req_t creq;
  psh_pkg::cvt_rsp_t crsp;
  logic cvt_issued;

  // Reduce each coordinate modulo the image side
  assign addr_a = {cmd.y_first[AW-1:0], cmd.x_first[AW-1:0]};
  assign addr_b = {cmd.y_second[AW-1:0], cmd.x_second[AW-1:0]};
  // Hold the B address while the B pixels are captured
  assign rd_addr = (state == psh_pkg::ST_RD_B || state == psh_pkg::ST_CV_SA) ?
                   addr_b : addr_a;

  // Image memories: one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    src_q <= src_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == psh_pkg::ST_RD_A && cmd.opcode == psh_pkg::OP_WRITE_TGT)
      tgt_mem[addr_a] <= cmd.pixel_value;
    tgt_q <= tgt_mem[rd_addr];
  end

  always_comb begin
    src_we    = 1'b0;
    src_waddr = addr_a;
    src_wdata = cmd.pixel_value;
    unique case (state)
      psh_pkg::ST_RD_A: src_we = (cmd.opcode == psh_pkg::OP_WRITE_SRC);
      psh_pkg::ST_WB_A: begin
        src_we    = 1'b1;
        src_wdata = sb;
      end
      psh_pkg::ST_WB_B: begin
        src_we    = 1'b1;
        src_waddr = addr_b;
        src_wdata = sa;
      end
      default: src_we = 1'b0;
    endcase
  end

  psh_hsv u_hsv (
    .clk(clk),
    .rst(rst),
    .req(creq),
    .rsp(crsp)
  );

  function automatic logic [13:0] absd(input logic signed [13:0] a,
                                       input logic signed [13:0] b);
    logic signed [14:0] t;
    t = 15'(a) - 15'(b);
    return t[14] ? 14'(-t) : 14'(t);
  endfunction

  function automatic logic [32:0] werr(input logic [1:0] i, input logic [1:0] j,
                                       input logic signed [13:0] hh [4],
                                       input logic [11:0] ss [4],
                                       input logic [11:0] vv [4]);
    logic [23:0] eh, es, ev;
    eh = 24'(absd(hh[i], hh[j])) * 24'(psh_pkg::W_HUE);
    es = 24'(absd($signed({2'b0, ss[i]}), $signed({2'b0, ss[j]})))
       * 24'(psh_pkg::W_SAT);
    ev = 24'(absd($signed({2'b0, vv[i]}), $signed({2'b0, vv[j]})))
       * 24'(psh_pkg::W_VAL);
    return 33'(eh) + 33'(es) + 33'(ev);
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      psh_pkg::ST_IDLE: if (start) state_next = psh_pkg::ST_RD_A;
      psh_pkg::ST_RD_A: state_next = (cmd.opcode == psh_pkg::OP_TRIAL) ?
                                     psh_pkg::ST_RD_B : psh_pkg::ST_DONE;
      psh_pkg::ST_RD_B: state_next = psh_pkg::ST_CV_SA;
      psh_pkg::ST_CV_SA: if (crsp.done) state_next = psh_pkg::ST_CV_SB;
      psh_pkg::ST_CV_SB: if (crsp.done) state_next = psh_pkg::ST_CV_TA;
      psh_pkg::ST_CV_TA: if (crsp.done) state_next = psh_pkg::ST_CV_TB;
      psh_pkg::ST_CV_TB: if (crsp.done) state_next = psh_pkg::ST_SUM;
      // let the error sums register the last conversion
      psh_pkg::ST_SUM:  state_next = psh_pkg::ST_ERR;
      psh_pkg::ST_ERR:  state_next = do_swap ? psh_pkg::ST_WB_A : psh_pkg::ST_DONE;
      psh_pkg::ST_WB_A: state_next = psh_pkg::ST_WB_B;
      psh_pkg::ST_WB_B: state_next = psh_pkg::ST_DONE;
      psh_pkg::ST_DONE: state_next = psh_pkg::ST_IDLE;
      default:          state_next = psh_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy     = (state != psh_pkg::ST_IDLE);
    do_swap  = (cur_err > alt_err);
    creq.start = 1'b0;
    creq.rgb   = sa;
    unique case (state)
      psh_pkg::ST_CV_SA: creq.rgb = sa;
      psh_pkg::ST_CV_SB: creq.rgb = sb;
      psh_pkg::ST_CV_TA: creq.rgb = ta;
      psh_pkg::ST_CV_TB: creq.rgb = tb;
      default:           creq.rgb = sa;
    endcase
    if (state == psh_pkg::ST_CV_SA || state == psh_pkg::ST_CV_SB ||
        state == psh_pkg::ST_CV_TA || state == psh_pkg::ST_CV_TB)
      creq.start = !cvt_issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= psh_pkg::ST_IDLE;
      improvements <= '0;
      trials       <= '0;
      out_valid    <= 1'b0;
      cvt_issued   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= 1'b0;
      if (creq.start) cvt_issued <= 1'b1;
      if (crsp.done)  cvt_issued <= 1'b0;
      if (state == psh_pkg::ST_ERR) begin
        if (trials != '1) trials <= trials + 32'd1;
        if (do_swap && improvements != '1) improvements <= improvements + 32'd1;
      end
      if (state == psh_pkg::ST_DONE) out_valid <= 1'b1;
    end
  end

  // Payload registers: hold command, capture reads and conversions
  always_ff @(posedge clk) begin
    if (state == psh_pkg::ST_IDLE && start) begin
      cmd              <= in_beat;
      out_beat.swapped <= 1'b0;
    end
    if (state == psh_pkg::ST_RD_B) begin
      sa <= src_q;
      ta <= tgt_q;
    end
    if (state == psh_pkg::ST_CV_SA) begin
      sb <= src_q;
      tb <= tgt_q;
    end
    if (state == psh_pkg::ST_RD_B)
      out_beat.read_pixel <= (cmd.opcode == psh_pkg::OP_READ_SRC) ? src_q : '0;
    else if (state == psh_pkg::ST_DONE && cmd.opcode != psh_pkg::OP_TRIAL)
      out_beat.read_pixel <= (cmd.opcode == psh_pkg::OP_READ_SRC) ? src_q : '0;
    if (crsp.done) begin
      unique case (state)
        psh_pkg::ST_CV_SA: begin h[0] <= crsp.h; s[0] <= crsp.s; v[0] <= crsp.v; end
        psh_pkg::ST_CV_SB: begin h[1] <= crsp.h; s[1] <= crsp.s; v[1] <= crsp.v; end
        psh_pkg::ST_CV_TA: begin h[2] <= crsp.h; s[2] <= crsp.s; v[2] <= crsp.v; end
        default:           begin h[3] <= crsp.h; s[3] <= crsp.s; v[3] <= crsp.v; end
      endcase
    end
    if (state == psh_pkg::ST_ERR) out_beat.swapped <= do_swap;
    if (state == psh_pkg::ST_DONE) begin
      out_beat.improvement_count <= improvements;
      out_beat.trial_count       <= trials;
    end
  end

  // Error sums: current pairing A-A, B-B; swapped pairing A-B, B-A
  always_ff @(posedge clk) begin
    cur_err <= 34'(werr(2'd0, 2'd2, h, s, v)) + 34'(werr(2'd1, 2'd3, h, s, v));
    alt_err <= 34'(werr(2'd0, 2'd3, h, s, v)) + 34'(werr(2'd1, 2'd2, h, s, v));
  end

endmodule
